// ----- rtl/core/cmang_pkg.sv -----
`timescale 1ns / 1ps
package cmang_pkg;

    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 32;
    localparam int THR_W      = 31;
    localparam int WL_W       = 4;
    localparam int POS_W      = 5;
    localparam int FILL_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [FILL_W-1:0] FILL_LIMIT = 5'd31;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       end_of_frame;
    } in_word_t;

    typedef struct packed {
        logic [CH_W-1:0]            out_channel;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [POS_W-1:0]  pos;
        logic [FILL_W-1:0] cnt;
        logic              last;
    } job_t;

    typedef struct packed {
        logic                       en;
        logic [CH_W-1:0]            ch;
        logic [POS_W-1:0]           pos;
        logic signed [SAMPLE_W-1:0] data;
    } hist_wr_t;

    typedef enum logic {
        F_IDLE,
        F_EMIT
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

// ----- rtl/core/cmang_front.sv -----
`timescale 1ns / 1ps
module cmang_front import cmang_pkg::*; #(
    parameter int CHANNELS   = 8,
    parameter int MAX_WINDOW = 15
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_word_t         in_word,
    input  logic             width_mode,
    input  logic [WL_W-1:0]  window_length,
    input  logic             drained,
    output hist_wr_t         hist_wr,
    output logic             push_valid,
    input  logic             push_ready,
    output job_t             push_job
);

    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [FILL_W-1:0] MW     = FILL_W'(MAX_WINDOW);
    localparam logic [FILL_W-1:0] MW_ODD = MW[0] ? MW : MW - 1'b1;

    front_state_t      state_reg, state_next;
    logic [FILL_W-1:0] fill_reg [CHANNELS];
    logic [POS_W-1:0]  pos_reg  [CHANNELS];
    logic [CH_W-1:0]   e_ch_reg, e_ch_next;
    logic [POS_W-1:0]  e_pos_reg, e_pos_next;
    logic [FILL_W-1:0] e_f_reg, e_f_next;
    logic [FILL_W-1:0] k_reg, k_next;

    logic              accept, ch_ok;
    logic [CIW-1:0]    ci;
    logic [FILL_W-1:0] w_raw, w, h, f_old, f_new, m, k0, wk, mk;
    logic [POS_W-1:0]  pos_old, pos_new;

    assign ci      = CIW'(in_word.channel);
    assign ch_ok   = 32'(in_word.channel) < CHANNELS;
    assign w_raw   = FILL_W'(window_length | 4'd1);
    assign w       = (w_raw > MW) ? MW_ODD : w_raw;
    assign h       = w >> 1;
    assign f_old   = fill_reg[ci];
    assign f_new   = (f_old == FILL_LIMIT) ? f_old : f_old + 1'b1;
    assign pos_old = pos_reg[ci];
    assign pos_new = (pos_old == POS_W'(MW - 1'b1)) ? '0 : pos_old + 1'b1;
    assign m       = (f_new < w) ? f_new : w;
    assign k0      = (f_new > h) ? '0 : h - (f_new - 1'b1);
    assign wk      = w - k_reg;
    assign mk      = (e_f_reg < wk) ? e_f_reg : wk;
    assign in_ready = (state_reg == F_IDLE) && drained;
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        e_ch_next  = e_ch_reg;
        e_pos_next = e_pos_reg;
        e_f_next   = e_f_reg;
        k_next     = k_reg;
        hist_wr.en   = accept && ch_ok;
        hist_wr.ch   = in_word.channel;
        hist_wr.pos  = pos_old;
        hist_wr.data = width_mode ? in_word.sample_in
                     : {{16{in_word.sample_in[15]}}, in_word.sample_in[15:0]};
        push_valid = 1'b0;
        push_job   = '{ch: in_word.channel, pos: pos_new, cnt: m, last: 1'b0};
        case (state_reg)
            F_IDLE: begin
                if (accept && ch_ok) begin
                    if (in_word.end_of_frame) begin
                        state_next = F_EMIT;
                        e_ch_next  = in_word.channel;
                        e_pos_next = pos_new;
                        e_f_next   = f_new;
                        k_next     = k0;
                    end else if (f_new > h) begin
                        push_valid = 1'b1;
                    end
                end
            end
            F_EMIT: begin
                push_valid = 1'b1;
                push_job   = '{ch: e_ch_reg, pos: e_pos_reg, cnt: mk, last: k_reg == h};
                if (push_ready) begin
                    if (k_reg == h) begin
                        state_next = F_IDLE;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            for (int i = 0; i < CHANNELS; i++) begin
                fill_reg[i] <= '0;
                pos_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (accept && ch_ok) begin
                fill_reg[ci] <= in_word.end_of_frame ? '0 : f_new;
                pos_reg[ci]  <= in_word.end_of_frame ? '0 : pos_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        e_ch_reg  <= e_ch_next;
        e_pos_reg <= e_pos_next;
        e_f_reg   <= e_f_next;
        k_reg     <= k_next;
    end

endmodule

// ----- rtl/core/cmang_queue.sv -----
`timescale 1ns / 1ps
module cmang_queue import cmang_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign empty      = count_reg == 2'd0;
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- rtl/core/cmang_back.sv -----
`timescale 1ns / 1ps
module cmang_back import cmang_pkg::*; #(
    parameter int CHANNELS   = 8,
    parameter int MAX_WINDOW = 15
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  hist_wr_t         hist_wr,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  job_t             pop_job,
    input  logic [THR_W-1:0] gate_threshold,
    output logic             busy,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data
);

    localparam int DEPTH = CHANNELS * MAX_WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW + 1);
    localparam int BCW   = $clog2(SUM_W + 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_WINDOW - 1);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    back_state_t              state_reg, state_next;
    job_t                     job_reg, job_next;
    logic [POS_W-1:0]         idx_reg, idx_next;
    logic [FILL_W-1:0]        issue_reg, issue_next;
    logic                     pend_reg, pend_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic [SUM_W-1:0]         quo_reg, quo_next;
    logic [FILL_W-1:0]        rem_reg, rem_next;
    logic [BCW-1:0]           bit_reg, bit_next;
    logic                     mv_reg, mv_next;
    out_word_t                out_reg, out_next;

    logic [AW-1:0]            rd_addr, wr_addr;
    logic [FILL_W:0]          rem_sh;
    logic [SUM_W-1:0]         res;

    assign rd_addr = AW'(32'(job_reg.ch) * MAX_WINDOW + 32'(idx_reg));
    assign wr_addr = AW'(32'(hist_wr.ch) * MAX_WINDOW + 32'(hist_wr.pos));
    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign res     = neg_reg ? -quo_reg : quo_reg;
    assign busy      = state_reg != B_IDLE;
    assign pop_ready = state_reg == B_IDLE;
    assign m_valid   = mv_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (hist_wr.en) mem[wr_addr] <= hist_wr.data;
        rdata_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        issue_next = issue_reg;
        pend_next  = 1'b0;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        mv_next    = mv_reg && !m_ready;
        out_next   = out_reg;
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    job_next   = pop_job;
                    idx_next   = (pop_job.pos == '0) ? LAST_POS : pop_job.pos - 1'b1;
                    issue_next = '0;
                    acc_next   = '0;
                    state_next = B_READ;
                end
            end
            B_READ: begin
                if (pend_reg) acc_next = acc_reg + SUM_W'(rdata_reg);
                if (issue_reg < job_reg.cnt) begin
                    pend_next  = 1'b1;
                    issue_next = issue_reg + 1'b1;
                    idx_next   = (idx_reg == '0) ? LAST_POS : idx_reg - 1'b1;
                end else if (!pend_reg) begin
                    neg_next   = acc_reg[SUM_W-1];
                    quo_next   = acc_reg[SUM_W-1] ? -acc_reg : acc_reg;
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV: begin
                if (rem_sh >= {1'b0, job_reg.cnt}) begin
                    rem_next = FILL_W'(rem_sh - {1'b0, job_reg.cnt});
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[FILL_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BCW'(SUM_W - 1)) state_next = B_OUT;
            end
            B_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    out_next.out_channel = job_reg.ch;
                    out_next.sample_out  = (quo_reg < SUM_W'(gate_threshold)) ? '0
                                         : res[SAMPLE_W-1:0];
                    out_next.last_of_run = job_reg.last;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        idx_reg   <= idx_next;
        issue_reg <= issue_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        out_reg   <= out_next;
    end

    a_pend_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> state_reg == B_READ)
        else $error("read data pending outside read phase");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_DIV |-> rem_reg < job_reg.cnt)
        else $error("divider remainder out of range");
    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_READ |-> issue_reg <= job_reg.cnt)
        else $error("too many history reads issued");

endmodule

// ----- rtl/core/centered_moving_average_noise_gate.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_data  (in_word_t)
// m_        out        m_valid / m_ready      m_data  (out_word_t)
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each result reads m samples from the history memory, then runs the shared divider,
// one quotient bit per cycle over SUM_W quotient bits (SUM_W = 36 here).
// A sample is taken only once all results of the previous sample are computed.
// Reset is synchronous, active low; history memory has no reset.
// A stalled result output stalls the back end, then the queue, then s_ready.
module centered_moving_average_noise_gate import cmang_pkg::*; #(
    parameter int CHANNELS   = 8,
    parameter int MAX_WINDOW = 15
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic             mode_reg;
    logic [THR_W-1:0] thr_reg;
    logic [WL_W-1:0]  wl_reg;

    hist_wr_t hist_wr;
    job_t     push_job, pop_job;
    logic     push_valid, push_ready, pop_valid, pop_ready, q_empty, back_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
            thr_reg  <= '0;
            wl_reg   <= 4'd5;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WIDTH_MODE: mode_reg <= cfg_data[0];
                CFG_THRESHOLD:  thr_reg  <= cfg_data[THR_W-1:0];
                CFG_WINDOW:     wl_reg   <= cfg_data[WL_W-1:0];
                default: ;
            endcase
        end
    end

    cmang_front #(.CHANNELS(CHANNELS), .MAX_WINDOW(MAX_WINDOW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_word(s_data),
        .width_mode(mode_reg), .window_length(wl_reg),
        .drained(q_empty && !back_busy),
        .hist_wr(hist_wr),
        .push_valid(push_valid), .push_ready(push_ready), .push_job(push_job)
    );

    cmang_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push_valid(push_valid), .push_ready(push_ready), .push_job(push_job),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_job(pop_job),
        .empty(q_empty)
    );

    cmang_back #(.CHANNELS(CHANNELS), .MAX_WINDOW(MAX_WINDOW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .hist_wr(hist_wr),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_job(pop_job),
        .gate_threshold(thr_reg), .busy(back_busy),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

// ----- verif/centered_moving_average_noise_gate_tb.sv -----
`timescale 1ns / 1ps
module centered_moving_average_noise_gate_tb;
    import cmang_pkg::*;

    localparam int NCH       = 8;
    localparam int MAXW      = 15;
    localparam int STALL_CAP = 20000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    centered_moving_average_noise_gate i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // predictor state
    logic signed [31:0] ring [NCH][MAXW];
    int                 fill [NCH];
    int                 wpos [NCH];
    logic               mode_q;
    logic [30:0]        thr_q;
    logic [3:0]         wlen_q;

    in_word_t  pending_words [$];
    out_word_t expected_words [$];

    int  mismatches;
    int  words_in;
    int  words_out;
    int  frames_done;
    int  idle_cycles;
    bit  timed_out;
    bit  quiet;
    bit  hold_off;
    int  hold_left;
    bit  s_fire;

    function automatic logic signed [31:0] smooth(int ch, int m);
        logic signed [35:0] acc;
        logic signed [35:0] q;
        logic signed [35:0] mag;
        int                 idx;
        acc = '0;
        for (int k = 1; k <= m; k++) begin
            idx = (wpos[ch] + MAXW - k) % MAXW;
            acc += 36'(ring[ch][idx]);
        end
        q = (m == 0) ? 36'sd0 : acc / 36'(m);
        mag = (q < 0) ? -q : q;
        if (mag < $signed({5'b0, thr_q})) q = '0;
        return q[31:0];
    endfunction

    task automatic predict_word(in_word_t w);
        int        ch;
        int        win;
        int        half;
        int        f;
        int        m;
        int        k0;
        out_word_t r;
        ch = w.channel;
        if (ch >= NCH) return;
        ring[ch][wpos[ch]] = mode_q ? w.sample_in : {{16{w.sample_in[15]}}, w.sample_in[15:0]};
        wpos[ch] = (wpos[ch] + 1) % MAXW;
        if (fill[ch] < 31) fill[ch]++;
        win = wlen_q | 1;
        if (win > MAXW) win = MAXW;
        half = win / 2;
        f = fill[ch];
        r.out_channel = w.channel;
        if (!w.end_of_frame) begin
            if (f > half) begin
                m = (f < win) ? f : win;
                r.sample_out = smooth(ch, m);
                r.last_of_run = 1'b0;
                expected_words.push_back(r);
            end
            return;
        end
        k0 = (f > half) ? 0 : half - (f - 1);
        for (int k = k0; k <= half; k++) begin
            m = (f < win - k) ? f : win - k;
            r.sample_out = smooth(ch, m);
            r.last_of_run = (k == half);
            expected_words.push_back(r);
        end
        fill[ch] = 0;
        wpos[ch] = 0;
        frames_done++;
    endtask

    // driver
    int s_gap;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) begin
                predict_word(pending_words.pop_front());
                words_in++;
                if (!quiet && $urandom_range(0, 5) == 0) s_gap = $urandom_range(1, 11);
            end
            if (s_valid && !s_fire) begin
            end else if (s_gap > 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_valid <= 1'b1;
                s_data  <= pending_words[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver readiness
    int m_gap;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off) begin
                m_ready <= 1'b0;
                if (hold_left > 0) hold_left--;
                else hold_off <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) m_gap = $urandom_range(1, 11);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_word_t e;
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                words_out++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word ch=%0d data=%0d last=%0d",
                        m_data.out_channel, m_data.sample_out, m_data.last_of_run);
                end else begin
                    e = expected_words.pop_front();
                    if (e !== m_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: exp ch=%0d data=%0d last=%0d, got ch=%0d data=%0d last=%0d",
                                words_out, e.out_channel, e.sample_out, e.last_of_run,
                                m_data.out_channel, m_data.sample_out, m_data.last_of_run);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && idle_cycles >= STALL_CAP && !timed_out) begin
            timed_out = 1'b1;
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH_MODE: mode_q = val[0];
            CFG_THRESHOLD:  thr_q  = val[30:0];
            CFG_WINDOW:     wlen_q = val[3:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !s_valid);
        wait (expected_words.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_sample(int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 200)) - 100;
            2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    task automatic queue_frame(int ch, int len, int style);
        in_word_t w;
        for (int i = 0; i < len; i++) begin
            w.channel      = 3'(ch);
            w.sample_in    = rand_sample(style);
            w.end_of_frame = (i == len - 1);
            pending_words.push_back(w);
        end
    endtask

    task automatic queue_interleaved(int count);
        in_word_t w;
        for (int i = 0; i < count; i++) begin
            w.channel      = 3'($urandom_range(0, 7));
            w.sample_in    = rand_sample($urandom_range(0, 3));
            w.end_of_frame = ($urandom_range(0, 9) == 0);
            pending_words.push_back(w);
        end
    endtask

    initial begin
        in_word_t w;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH_MODE;
        cfg_data = '0;
        s_gap = 0;
        m_gap = 0;
        s_fire = 1'b0;
        hold_off = 1'b0;
        hold_left = 0;
        quiet = 1'b0;
        mismatches = 0;
        words_in = 0;
        words_out = 0;
        frames_done = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        mode_q = 1'b1;
        thr_q = '0;
        wlen_q = 4'd5;
        for (int c = 0; c < NCH; c++) begin
            fill[c] = 0;
            wpos[c] = 0;
            for (int j = 0; j < MAXW; j++) ring[c][j] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, single-sample frames, tiny frames
        w = '{channel: 3'd0, sample_in: 32'sh7fffffff, end_of_frame: 1'b0};
        pending_words.push_back(w);
        w.sample_in = 32'sh7fffffff;
        pending_words.push_back(w);
        w.sample_in = 32'sh80000000;
        w.end_of_frame = 1'b1;
        pending_words.push_back(w);
        w = '{channel: 3'd7, sample_in: 32'sh80000000, end_of_frame: 1'b1};
        pending_words.push_back(w);
        queue_frame(3, 2, 2);
        queue_frame(5, 6, 0);
        drain();

        write_reg(CFG_WINDOW, 32'd15);
        write_reg(CFG_THRESHOLD, 32'h7fffffff);
        queue_frame(1, 4, 0);
        drain();
        write_reg(CFG_THRESHOLD, 32'd50);
        queue_frame(2, 20, 1);
        drain();
        write_reg(CFG_WIDTH_MODE, 32'd0);
        write_reg(CFG_WINDOW, 32'd0);
        write_reg(CFG_THRESHOLD, 32'd0);
        queue_frame(4, 3, 3);
        drain();

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_WIDTH_MODE, $urandom_range(0, 1));
            write_reg(CFG_WINDOW, (ph == 0) ? 32'd14 : $urandom_range(0, 15));
            write_reg(CFG_THRESHOLD, (ph == 2) ? 32'd40000 : $urandom_range(0, 60));
            if (ph == 1) begin
                hold_left = 600;
                hold_off = 1'b1;
            end
            for (int fcnt = 0; fcnt < 4; fcnt++)
                queue_frame($urandom_range(0, 7), $urandom_range(1, 12), $urandom_range(0, 3));
            queue_interleaved(10);
            if (ph == 5) quiet = 1'b1;
            drain();
        end

        if (mismatches == 0) begin
            $display("%0d samples in, %0d smoothed words out, %0d frames closed",
                words_in, words_out, frames_done);
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches over %0d words", mismatches, words_out);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cmang_pkg.sv
rtl/core/cmang_front.sv
rtl/core/cmang_queue.sv
rtl/core/cmang_back.sv
rtl/core/centered_moving_average_noise_gate.sv
verif/centered_moving_average_noise_gate_tb.sv
